// ===== sv/pfla_pkg.sv =====
// ----------------------------------------------------------------------------
// pfla_pkg: shared types and codes for the page free-list allocator
// Holds the request and response beat types, the action and status codes,
// and the request bundle sent to the link memory.
// ----------------------------------------------------------------------------
package pfla_pkg;

	localparam int unsigned PageW = 10;

	typedef logic [PageW-1:0] page_t;

	// Action codes; code 3 is a no-op and is served by default arms
	typedef enum logic [1:0] {
		ACT_ALLOC  = 2'd0,
		ACT_FREE   = 2'd1,
		ACT_FORMAT = 2'd2
	} action_t;

	localparam logic [1:0] STATUS_OK     = 2'd0;
	localparam logic [1:0] STATUS_FULL   = 2'd1;
	localparam logic [1:0] STATUS_REJECT = 2'd2;

	typedef struct packed {
		logic [1:0] action;
		page_t      page_number;
	} pfla_req_t;

	typedef struct packed {
		page_t      granted_page;
		logic [1:0] status;
	} pfla_rsp_t;

	// Access to the link memory: at most one of read or write per cycle
	typedef struct packed {
		logic  rd_en;
		logic  wr_en;
		page_t addr;
		page_t wdata;
	} link_req_t;

endpackage

// ===== sv/pfla_link_mem.sv =====
// ----------------------------------------------------------------------------
// pfla_link_mem: next-link store of the free list
// Single-port synchronous memory with a registered read.
// ----------------------------------------------------------------------------
module pfla_link_mem import pfla_pkg::*; #(
	parameter int unsigned DEPTH = 1024
) (
	input  logic      clk,
	input  link_req_t req,
	output page_t     rdata
);

	localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	page_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.addr[AddrW-1:0]] <= req.wdata;
		end
		if (req.rd_en) begin
			rdata <= mem[req.addr[AddrW-1:0]];
		end
	end

endmodule

// ===== sv/page_free_list_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// page_free_list_allocator_unit: free-list page allocator with bump pointer
// Allocate pops the free-list head or bumps the top page; free shrinks the
// top or pushes the page onto the list; format empties everything.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake              | beat
//  --------+-----------+------------------------+-----------------------------
//  req     | in        | req_valid / req_ready  | action, page_number
//  rsp     | out       | rsp_valid / rsp_ready  | granted_page, status
//
//  Allocate from a non-empty free list goes through S_POP: the head's link is
//  read from the link memory, whose read data arrives in the next cycle.
//  Every other beat (bump allocate, free, format, no-op) is answered from S_IDLE.
//  Reset clears the head, empty flag and top page at once; the link memory
//  needs no clearing pass, since a link is only read after it was written.
//  A new request is taken while idle and the response register is empty or
//  drained in the same cycle, so a stalled rsp side holds at most one beat.
//
module page_free_list_allocator_unit import pfla_pkg::*; #(
	parameter int unsigned PAGE_COUNT = 1024
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  pfla_req_t req,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output pfla_rsp_t rsp
);

	// Highest grantable page: capped by the 10-bit page field
	localparam int unsigned PageMax   = (1 << PageW) - 1;
	localparam int unsigned LastPageI = (PAGE_COUNT - 1 > PageMax) ? PageMax : PAGE_COUNT - 1;
	localparam page_t       LastPage  = PageW'(LastPageI);
	// Only pages up to LastPage ever reach the list
	localparam int unsigned LinkDepth = LastPageI + 1;

	typedef enum logic {
		S_IDLE,
		S_POP
	} state_t;

	state_t    state_q;
	logic      rsp_valid_q;
	pfla_rsp_t rsp_q;
	page_t     list_head_q;
	logic      list_empty_q;
	page_t     top_page_q;

	link_req_t link_req;
	page_t     link_rdata;
	logic      req_fire;
	logic      rsp_load;
	logic      is_alloc;
	logic      is_free;
	logic      free_bad;

	// Take a beat only when idle and the response slot is empty or frees up this cycle
	assign req_ready = (state_q == S_IDLE) && (!rsp_valid_q || rsp_ready);
	assign req_fire  = req_valid && req_ready;
	// A response beat is loaded this cycle: end of a pop, or any other request
	assign rsp_load  = (state_q == S_POP) || (req_fire && !link_req.rd_en);

	assign is_alloc = (req.action == ACT_ALLOC);
	assign is_free  = (req.action == ACT_FREE);
	// Reject the header page and anything above the top
	assign free_bad = (req.page_number == '0) || (req.page_number > top_page_q);

	// Read the head's link on a pop; write the old head into a pushed page
	always_comb begin
		link_req.rd_en = req_fire && is_alloc && !list_empty_q;
		link_req.wr_en = req_fire && is_free && !free_bad
			&& (req.page_number != top_page_q);
		link_req.addr  = link_req.rd_en ? list_head_q : req.page_number;
		link_req.wdata = list_empty_q ? '0 : list_head_q;
	end

	pfla_link_mem #(
		.DEPTH(LinkDepth)
	) u_link_mem (
		.clk  (clk),
		.req  (link_req),
		.rdata(link_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			rsp_valid_q  <= 1'b0;
			list_head_q  <= '0;
			list_empty_q <= 1'b1;
			top_page_q   <= '0;
		end else begin
			// Drop the held beat once taken, unless a new one loads below
			if (rsp_valid_q && rsp_ready && !rsp_load) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						case (req.action)
							ACT_ALLOC: begin
								if (!list_empty_q) begin
									// Wait for the link read
									state_q <= S_POP;
								end else if (top_page_q >= LastPage) begin
									rsp_q       <= '{granted_page: '0, status: STATUS_FULL};
									rsp_valid_q <= 1'b1;
								end else begin
									top_page_q  <= top_page_q + PageW'(1);
									rsp_q       <= '{granted_page: top_page_q + PageW'(1),
										status: STATUS_OK};
									rsp_valid_q <= 1'b1;
								end
							end
							ACT_FREE: begin
								if (free_bad) begin
									rsp_q <= '{granted_page: '0, status: STATUS_REJECT};
								end else begin
									if (req.page_number == top_page_q) begin
										// Shrink the top; listed pages stay listed
										top_page_q <= top_page_q - PageW'(1);
									end else begin
										list_head_q  <= req.page_number;
										list_empty_q <= 1'b0;
									end
									rsp_q <= '{granted_page: '0, status: STATUS_OK};
								end
								rsp_valid_q <= 1'b1;
							end
							ACT_FORMAT: begin
								list_head_q  <= '0;
								list_empty_q <= 1'b1;
								top_page_q   <= '0;
								rsp_q        <= '{granted_page: '0, status: STATUS_OK};
								rsp_valid_q  <= 1'b1;
							end
							default: begin
								rsp_q       <= '{granted_page: '0, status: STATUS_OK};
								rsp_valid_q <= 1'b1;
							end
						endcase
					end
				end
				S_POP: begin
					// Grant the old head and advance to its link
					rsp_q        <= '{granted_page: list_head_q, status: STATUS_OK};
					rsp_valid_q  <= 1'b1;
					list_head_q  <= link_rdata;
					list_empty_q <= (link_rdata == '0);
					state_q      <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef ASSERT_OFF
	// A pop always delivers its beat in the following cycle
	a_pop_delivers: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_POP) |=> rsp_valid_q)
		else $error("pop did not deliver a response beat");

	// No new request while a link read is outstanding
	a_pop_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_POP) |-> !req_ready)
		else $error("request accepted during pop");

	// Empty list and zero head go together (page 0 is never listed)
	a_head_empty: assert property (@(posedge clk) disable iff (!arst_n)
		list_empty_q == (list_head_q == '0))
		else $error("list head and empty flag disagree");

	// The top never passes the last page
	a_top_range: assert property (@(posedge clk) disable iff (!arst_n)
		top_page_q <= LastPage)
		else $error("top page beyond last page");

	// A link read is issued only for an accepted allocate
	a_read_on_fire: assert property (@(posedge clk) disable iff (!arst_n)
		link_req.rd_en |-> (req_fire && !link_req.wr_en))
		else $error("stray link memory read");
`endif

endmodule

// ===== test/pfla_checker.sv =====
// ----------------------------------------------------------------------------
// pfla_checker: response predictor and scoreboard for the page allocator
// Watches both channels. Each accepted request beat updates a private copy of
// the allocator state and queues the response it must produce. Each accepted
// response beat is compared field by field with the oldest queued one.
// ----------------------------------------------------------------------------
module pfla_checker import pfla_pkg::*; #(
	parameter int unsigned PAGE_COUNT = 1024
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	input  logic      req_ready,
	input  pfla_req_t req,
	input  logic      rsp_valid,
	input  logic      rsp_ready,
	input  pfla_rsp_t rsp,
	output int        mismatches,
	output int        owed,
	output int        pops,
	output int        bumps,
	output int        fulls,
	output int        rejects
);
	timeunit 1ns;
	timeprecision 1ps;

	// Highest grantable page, capped by the page field width
	localparam int unsigned LastPage = (PAGE_COUNT - 1 > 1023) ? 1023 : PAGE_COUNT - 1;

	page_t     link_mem [1024];
	page_t     head_pg   = '0;
	logic      list_void = 1'b1;
	page_t     top_pg    = '0;
	pfla_rsp_t owed_rsp [$];

	int n_mismatch = 0;
	int n_pop      = 0;
	int n_bump     = 0;
	int n_full     = 0;
	int n_reject   = 0;

	assign mismatches = n_mismatch;
	assign owed       = owed_rsp.size();
	assign pops       = n_pop;
	assign bumps      = n_bump;
	assign fulls      = n_full;
	assign rejects    = n_reject;

	function automatic pfla_rsp_t serve_request(pfla_req_t r);
		pfla_rsp_t o;
		o.granted_page = '0;
		o.status       = STATUS_OK;
		case (action_t'(r.action))
			ACT_ALLOC: begin
				if (!list_void) begin
					o.granted_page = head_pg;
					head_pg        = link_mem[head_pg];
					list_void      = (head_pg == '0);
					n_pop++;
				end else if (int'(top_pg) + 1 > int'(LastPage)) begin
					o.status = STATUS_FULL;
					n_full++;
				end else begin
					top_pg         = top_pg + 1'b1;
					o.granted_page = top_pg;
					n_bump++;
				end
			end
			ACT_FREE: begin
				if (r.page_number == '0 || r.page_number > top_pg) begin
					o.status = STATUS_REJECT;
					n_reject++;
				end else if (r.page_number == top_pg) begin
					top_pg = top_pg - 1'b1;
				end else begin
					// push: a link of 0 marks the end of the list
					link_mem[r.page_number] = list_void ? page_t'(0) : head_pg;
					head_pg                 = r.page_number;
					list_void               = 1'b0;
				end
			end
			ACT_FORMAT: begin
				head_pg   = '0;
				list_void = 1'b1;
				top_pg    = '0;
			end
			default: ;
		endcase
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pfla_rsp_t due;
		if (!arst_n) begin
			head_pg   = '0;
			list_void = 1'b1;
			top_pg    = '0;
			owed_rsp.delete();
		end else begin
			// compare first: a request taken at this edge answers later
			if (rsp_valid && rsp_ready) begin
				if (owed_rsp.size() == 0) begin
					$error("unexpected response beat: granted_page %0d status %0d",
						rsp.granted_page, rsp.status);
					n_mismatch++;
				end else begin
					due = owed_rsp.pop_front();
					if (rsp.granted_page !== due.granted_page) begin
						$error("granted_page: expected %0d, actual %0d",
							due.granted_page, rsp.granted_page);
						n_mismatch++;
					end
					if (rsp.status !== due.status) begin
						$error("status: expected %0d, actual %0d", due.status, rsp.status);
						n_mismatch++;
					end
				end
			end
			if (req_valid && req_ready)
				owed_rsp.push_back(serve_request(req));
		end
	end

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the page free-list allocator
// Drives a directed opening, then random allocate/free/format traffic with a
// full fill of the page file, under random gaps on both channels and one long
// response stall. Checking is done by pfla_checker beside the block.
// ----------------------------------------------------------------------------
module tb import pfla_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	// Generous: ~1850 beats at the slowest pace, plus the long stall
	localparam int          TimeoutCycles = 400000;
	localparam logic [1:0]  ActNoop       = 2'd3;
	localparam int          LongStall     = 250;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_ready;
	pfla_req_t req       = '0;
	logic      rsp_valid;
	logic      rsp_ready = 1'b0;
	pfla_rsp_t rsp;

	int    mismatches, owed, pops, bumps, fulls, rejects;
	int    cycle_count = 0;
	int    sent        = 0;
	int    rx_beats    = 0;
	// Rough guess of the top page, used only to aim frees at live pages
	page_t top_hint    = '0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	page_free_list_allocator_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	pfla_checker u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp        (rsp),
		.mismatches (mismatches),
		.owed       (owed),
		.pops       (pops),
		.bumps      (bumps),
		.fulls      (fulls),
		.rejects    (rejects)
	);

	// Watchdog: end the run if the traffic never drains
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= TimeoutCycles) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Wait before the next beat: random, except in calm stretches of beats
	function automatic int pick_gap(int n, int period);
		if ((n / period) % 4 == 1)
			return 0;
		return $urandom_range(0, 18);
	endfunction

	// Offer one request beat and hold it until taken. Enter and leave on a
	// falling edge, so each step sees at most one update of req_valid.
	task automatic send_beat(input logic [1:0] act, input page_t pg);
		int gap;
		gap = pick_gap(sent, 64);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid <= 1'b1;
		req       <= '{action: act, page_number: pg};
		do @(posedge clk); while (!req_ready);
		@(negedge clk);
		sent++;
		// track the top roughly; list pops are not seen here
		case (act)
			ACT_ALLOC:  if (top_hint != '1) top_hint = top_hint + 1'b1;
			ACT_FREE:   if (pg == top_hint && pg != '0) top_hint = top_hint - 1'b1;
			ACT_FORMAT: top_hint = '0;
			default:    ;
		endcase
	endtask

	// One random beat: mostly allocate and free around the live pages, with
	// some no-ops, the odd wild page number and, where allowed, a format.
	task automatic send_mixed(input bit allow_format);
		int    r;
		int    hi;
		page_t pg;
		r  = $urandom_range(0, 99);
		hi = (int'(top_hint) + 1 > 1023) ? 1023 : int'(top_hint) + 1;
		if (r < 48) begin
			send_beat(ACT_ALLOC, page_t'($urandom));
		end else if (r < 94) begin
			pg = ($urandom_range(0, 6) == 0) ? page_t'($urandom) : page_t'($urandom_range(0, hi));
			send_beat(ACT_FREE, pg);
		end else if (r < 99 || !allow_format) begin
			send_beat(ActNoop, page_t'($urandom));
		end else begin
			send_beat(ACT_FORMAT, page_t'($urandom));
		end
	endtask

	// Response side: random hold-offs per beat, calm stretches, and one long
	// stall so the block fills up and back-pressures its request side.
	initial begin
		int w;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			w = (rx_beats == 400) ? LongStall : pick_gap(rx_beats, 50);
			if (w > 0) begin
				rsp_ready <= 1'b0;
				repeat (w) @(negedge clk);
			end
			rsp_ready <= 1'b1;
			do @(posedge clk); while (!rsp_valid);
			@(negedge clk);
			rx_beats++;
		end
	end

	initial begin
		// Hold reset, then release it on a falling edge
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed opening: bump allocate, push, shrink the top, pop
		send_beat(ACT_ALLOC, 10'h3FF);
		send_beat(ACT_ALLOC, 10'h000);
		send_beat(ACT_ALLOC, 10'h2AA);
		send_beat(ACT_ALLOC, 10'h155);
		send_beat(ACT_FREE, 10'd2);
		send_beat(ACT_FREE, 10'd3);
		// header page and a page above the top are refused
		send_beat(ACT_FREE, 10'd0);
		send_beat(ACT_FREE, 10'h3FF);
		// shrink the top twice, the second time below a listed page
		send_beat(ACT_FREE, 10'd4);
		send_beat(ACT_FREE, 10'd3);
		// back-to-back pops, then the list runs dry and the top bumps
		send_beat(ACT_ALLOC, 10'd0);
		send_beat(ACT_ALLOC, 10'd0);
		send_beat(ACT_ALLOC, 10'd0);
		// unknown action does nothing
		send_beat(ActNoop, 10'h3FF);
		send_beat(ACT_FORMAT, 10'h3FF);
		send_beat(ACT_ALLOC, 10'd0);
		send_beat(ACT_FREE, 10'd1);
		send_beat(ACT_FREE, 10'd1);
		send_beat(ACT_ALLOC, 10'd0);
		send_beat(ACT_ALLOC, 10'd0);
		// freeing the same page twice links it to itself
		send_beat(ACT_FREE, 10'd1);
		send_beat(ACT_FREE, 10'd1);
		send_beat(ACT_ALLOC, 10'd0);
		send_beat(ACT_ALLOC, 10'd0);
		send_beat(ACT_FORMAT, 10'd0);

		// Mixed traffic from a fresh file
		repeat (300) send_mixed(1'b1);

		// Fill the whole file, then run into the end of it
		send_beat(ACT_FORMAT, page_t'($urandom));
		repeat (1026) send_beat(ACT_ALLOC, page_t'($urandom));
		repeat (40) begin
			if ($urandom_range(0, 1) != 0)
				send_beat(ACT_FREE, page_t'($urandom_range(1000, 1023)));
			else
				send_beat(ACT_ALLOC, page_t'($urandom));
		end

		// Mixed traffic again with the odd format thrown in
		send_beat(ACT_FORMAT, page_t'($urandom));
		repeat (430) send_mixed(1'b1);

		req_valid <= 1'b0;

		// Drain, then idle on so that any stray beat would still show
		while (owed != 0) @(negedge clk);
		repeat (8) @(negedge clk);

		$display("Sent %0d request beats under random gaps and one %0d-cycle response stall.",
			sent, LongStall);
		$display("Seen %0d list pops, %0d top bumps, %0d full refusals, %0d rejected frees.",
			pops, bumps, fulls, rejects);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
